// File: design/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg: shared definitions for the ray and box slab test
// Register indexes, distance format constants and the per-lane side-band type
// that travels with each division through the pipeline.
// ----------------------------------------------------------------------------
package rbs_pkg;

  // Width of a slab distance before the final clamp to the result fields.
  localparam int T_W       = 32;
  // Width of the t_near and t_far result fields.
  localparam int T_OUT_W   = 31;
  // Fraction bits of a direction component.
  localparam int DIR_FRAC  = 14;
  localparam int CFG_ADDR_W = 3;

  localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

  // Box bounds after reset: -50.0 and +50.0 in Q16.16.
  localparam logic signed [31:0] BOX_MIN_RESET = -32'sd3276800;
  localparam logic signed [31:0] BOX_MAX_RESET = 32'sd3276800;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BOX_MAX_Z = 3'd5;

  // Side-band information carried alongside one slab division.
  typedef struct packed {
    logic res_neg;  // quotient is to be negated
    logic d_neg;    // direction component is negative
    logic d_zero;   // direction component is zero
    logic in_slab;  // origin lies between the two bounds of this axis
  } lane_tag_t;

endpackage

// File: design/rbs_div.sv
// ----------------------------------------------------------------------------
// rbs_div: pipelined unsigned divider
// Restoring division, one quotient bit per register stage, with a side-band
// tag that moves in step with the operands.
// ----------------------------------------------------------------------------
module rbs_div #(
  parameter int NUM_W = 47,
  parameter int DEN_W = 16,
  parameter int TAG_W = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic [NUM_W-1:0] quo,
  output logic [TAG_W-1:0] tag_out
);

  logic [DEN_W-1:0] rem   [NUM_W];
  logic [NUM_W-1:0] nrest [NUM_W];
  logic [NUM_W-1:0] qacc  [NUM_W];
  logic [DEN_W-1:0] dens  [NUM_W];
  logic [TAG_W-1:0] tags  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_prev;
    logic [NUM_W-1:0] nrest_prev;
    logic [NUM_W-1:0] qacc_prev;
    logic [DEN_W-1:0] den_prev;
    logic [TAG_W-1:0] tag_prev;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_prev   = '0;
      assign nrest_prev = num;
      assign qacc_prev  = '0;
      assign den_prev   = den;
      assign tag_prev   = tag_in;
    end else begin : g_next
      assign rem_prev   = rem[k-1];
      assign nrest_prev = nrest[k-1];
      assign qacc_prev  = qacc[k-1];
      assign den_prev   = dens[k-1];
      assign tag_prev   = tags[k-1];
    end

    assign trial = {rem_prev, nrest_prev[NUM_W-1]};
    assign diff  = trial - {1'b0, den_prev};
    assign ge    = trial >= {1'b0, den_prev};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nrest[k] <= {nrest_prev[NUM_W-2:0], 1'b0};
        qacc[k]  <= {qacc_prev[NUM_W-2:0], ge};
        dens[k]  <= den_prev;
        tags[k]  <= tag_prev;
      end
    end
  end

  assign quo     = qacc[NUM_W-1];
  assign tag_out = tags[NUM_W-1];

endmodule

// File: design/ray_box_slab_intersection.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersection: ray against axis-aligned box, slab method
// Fully pipelined fixed-point test of one ray per clock, while the output is not
// stalled, against a box held in six configuration registers.
// ----------------------------------------------------------------------------
// Each item is one ray (Q16.16 origin, Q2.14 direction). The block accepts a
// new item in every cycle while the output is not stalled and returns one
// result item per ray, in order. The pipeline holds up to COORD_WIDTH + 19
// items. Most of its depth is taken by the six slab divisions, which run in
// parallel as restoring dividers producing one quotient bit per stage;
// the remaining stages register the input, the clamp and swap, the interval
// intersection and the result. The whole pipeline advances whenever the output
// register is empty or being taken, so back-pressure freezes every item in
// place and nothing is dropped or repeated. Slab distances are
// (bound - origin) * 2^14 / direction, rounded towards zero and saturated to
// the signed 32-bit range; a zero direction component passes its slab only
// when the origin lies between the bounds. A miss returns zero distances, and
// an origin inside the box reports the exit distance as the entry distance.
// The box registers should only be written while no item is in flight.
// ----------------------------------------------------------------------------
module ray_box_slab_intersection #(
  parameter int COORD_WIDTH = 32,
  parameter int DIR_WIDTH   = 16
) (
  input  logic clk,
  input  logic rst,
  // Slave side tdata, from bit 0: origin_x, origin_y, origin_z,
  // dir_x, dir_y, dir_z, then zero fill to a whole byte.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((3*COORD_WIDTH+3*DIR_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // Master side tdata, from bit 0: hit, t_near, t_far, then one zero bit.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [63:0]                           m_axis_tdata,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic [rbs_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [COORD_WIDTH-1:0]                cfg_data
);

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = DIR_WIDTH;
  localparam int TW    = rbs_pkg::T_W;
  localparam int OW    = rbs_pkg::T_OUT_W;
  localparam int NUM_W = CW + 1 + rbs_pkg::DIR_FRAC;
  localparam int QX    = (NUM_W > TW + 1) ? NUM_W : TW + 1;
  localparam int TAG_W = $bits(rbs_pkg::lane_tag_t);
  localparam logic [QX-1:0] POS_LIM = QX'((64'd1 << (TW - 1)) - 64'd1);
  localparam logic [QX-1:0] NEG_LIM = QX'(64'd1 << (TW - 1));

  // Box registers: index 0 to 2 lower bounds, 3 to 5 upper bounds.
  logic signed [CW-1:0] box_lo [3];
  logic signed [CW-1:0] box_hi [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        box_lo[i] <= CW'(rbs_pkg::BOX_MIN_RESET);
        box_hi[i] <= CW'(rbs_pkg::BOX_MAX_RESET);
      end
    end else if (cfg_we) begin
      case (cfg_addr)
        rbs_pkg::REG_BOX_MIN_X: box_lo[0] <= cfg_data;
        rbs_pkg::REG_BOX_MIN_Y: box_lo[1] <= cfg_data;
        rbs_pkg::REG_BOX_MIN_Z: box_lo[2] <= cfg_data;
        rbs_pkg::REG_BOX_MAX_X: box_hi[0] <= cfg_data;
        rbs_pkg::REG_BOX_MAX_Y: box_hi[1] <= cfg_data;
        rbs_pkg::REG_BOX_MAX_Z: box_hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // One enable for the whole pipeline: it moves when the result register is
  // free or its item is being taken.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Valid bits: input register, divider stages, clamp stage, intersect stage.
  logic             v_in;
  logic [NUM_W-1:0] v_div;
  logic             v_clamp;
  logic             v_isect;

  // Input register.
  logic signed [CW-1:0] org [3];
  logic signed [DW-1:0] dir [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        org[i] <= s_axis_tdata[i*CW +: CW];
        dir[i] <= s_axis_tdata[3*CW + i*DW +: DW];
      end
    end
  end

  // Numerator set-up and the six dividers: lane a is the lower bound, lane b
  // the upper bound of each axis.
  logic [NUM_W-1:0]   quo_a [3];
  logic [NUM_W-1:0]   quo_b [3];
  rbs_pkg::lane_tag_t tag_a [3];
  rbs_pkg::lane_tag_t tag_b [3];

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    logic signed [CW:0] diff_a;
    logic signed [CW:0] diff_b;
    logic [CW:0]        mag_a;
    logic [CW:0]        mag_b;
    logic [DW-1:0]      dmag;
    logic [DW-1:0]      den;
    logic               dneg;
    logic               dzero;
    logic               org_in_slab;
    rbs_pkg::lane_tag_t tin_a;
    rbs_pkg::lane_tag_t tin_b;

    assign diff_a = {box_lo[ax][CW-1], box_lo[ax]} - {org[ax][CW-1], org[ax]};
    assign diff_b = {box_hi[ax][CW-1], box_hi[ax]} - {org[ax][CW-1], org[ax]};
    assign mag_a  = diff_a[CW] ? -diff_a : diff_a;
    assign mag_b  = diff_b[CW] ? -diff_b : diff_b;
    assign dneg   = dir[ax][DW-1];
    assign dzero  = (dir[ax] == '0);
    assign dmag   = dneg ? -dir[ax] : dir[ax];
    // A zero divisor is replaced so the divider sees a defined operand; its
    // quotient is not used.
    assign den    = dzero ? DW'(1) : dmag;
    assign org_in_slab = (org[ax] >= box_lo[ax]) && (org[ax] <= box_hi[ax]);

    assign tin_a = '{res_neg: diff_a[CW] ^ dneg, d_neg: dneg, d_zero: dzero,
                     in_slab: org_in_slab};
    assign tin_b = '{res_neg: diff_b[CW] ^ dneg, d_neg: dneg, d_zero: dzero,
                     in_slab: org_in_slab};

    rbs_div #(.NUM_W(NUM_W), .DEN_W(DW), .TAG_W(TAG_W)) u_div_a (
      .clk     (clk),
      .en      (en),
      .num     ({mag_a, {rbs_pkg::DIR_FRAC{1'b0}}}),
      .den     (den),
      .tag_in  (tin_a),
      .quo     (quo_a[ax]),
      .tag_out (tag_a[ax])
    );

    rbs_div #(.NUM_W(NUM_W), .DEN_W(DW), .TAG_W(TAG_W)) u_div_b (
      .clk     (clk),
      .en      (en),
      .num     ({mag_b, {rbs_pkg::DIR_FRAC{1'b0}}}),
      .den     (den),
      .tag_in  (tin_b),
      .quo     (quo_b[ax]),
      .tag_out (tag_b[ax])
    );
  end

  // Apply the sign, saturate to 32 bits and order each slab interval.
  function automatic logic signed [TW-1:0] sat_t(input logic [NUM_W-1:0] q,
                                                 input logic neg);
    logic [QX-1:0] qx;
    logic [TW-1:0] low;
    qx  = QX'(q);
    low = qx[TW-1:0];
    if (!neg) begin
      sat_t = (qx > POS_LIM) ? rbs_pkg::T_MAX : low;
    end else begin
      sat_t = (qx > NEG_LIM) ? rbs_pkg::T_MIN : -low;
    end
  endfunction

  logic signed [TW-1:0] tn [3];
  logic signed [TW-1:0] tf [3];
  logic [2:0]           slab_ok;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (tag_a[i].d_zero) begin
          tn[i]      <= rbs_pkg::T_MIN;
          tf[i]      <= rbs_pkg::T_MAX;
          slab_ok[i] <= tag_a[i].in_slab;
        end else if (tag_a[i].d_neg) begin
          tn[i]      <= sat_t(quo_b[i], tag_b[i].res_neg);
          tf[i]      <= sat_t(quo_a[i], tag_a[i].res_neg);
          slab_ok[i] <= 1'b1;
        end else begin
          tn[i]      <= sat_t(quo_a[i], tag_a[i].res_neg);
          tf[i]      <= sat_t(quo_b[i], tag_b[i].res_neg);
          slab_ok[i] <= 1'b1;
        end
      end
    end
  end

  // Intersect the three intervals.
  logic signed [TW-1:0] near_v;
  logic signed [TW-1:0] far_v;
  logic                 all_ok;
  logic signed [TW-1:0] near_01;
  logic signed [TW-1:0] far_01;

  assign near_01 = (tn[1] > tn[0]) ? tn[1] : tn[0];
  assign far_01  = (tf[1] < tf[0]) ? tf[1] : tf[0];

  always_ff @(posedge clk) begin
    if (en) begin
      near_v <= (tn[2] > near_01) ? tn[2] : near_01;
      far_v  <= (tf[2] < far_01) ? tf[2] : far_01;
      all_ok <= &slab_ok;
    end
  end

  // Final decision; an origin inside the box reports far as near.
  logic                 hit_c;
  logic signed [TW-1:0] near_c;
  logic                 hit;
  logic [OW-1:0]        t_near;
  logic [OW-1:0]        t_far;

  always_comb begin
    hit_c  = all_ok && !(near_v > far_v);
    near_c = near_v;
    if (hit_c && near_v < 0) begin
      near_c = far_v;
      if (far_v < 0) begin
        hit_c = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit    <= hit_c;
      t_near <= hit_c ? near_c[OW-1:0] : '0;
      t_far  <= hit_c ? far_v[OW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in          <= 1'b0;
      v_div         <= '0;
      v_clamp       <= 1'b0;
      v_isect       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v_in          <= s_axis_tvalid;
      v_div         <= {v_div[NUM_W-2:0], v_in};
      v_clamp       <= v_div[NUM_W-1];
      v_isect       <= v_clamp;
      m_axis_tvalid <= v_isect;
    end
  end

  assign m_axis_tdata = {1'b0, t_far, t_near, hit};

  // A reported hit never has its entry beyond its exit.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && hit |-> t_near <= t_far)
    else $error("hit with entry distance beyond exit distance");

  // A miss carries zero distances.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !hit |-> t_near == '0 && t_far == '0)
    else $error("miss with non-zero distances");

  // A held result stays put and the pipeline is frozen behind it.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(v_div))
    else $error("pipeline moved while the result was stalled");

  // Nothing leaves the pipeline in the cycle after reset.
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid straight after reset");

endmodule

// File: tb/tb_ray_box_slab_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_box_slab_intersection: self-checking bench for the slab intersector
// Drives rays through the stream input under random idling on both sides,
// predicts each hit flag and distance pair in fixed point and compares every
// result item with the oldest expected result. The box is rewritten between phases
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_intersection;

  // Pipeline depth with the default widths.
  localparam int LATENCY = 51;

  typedef struct packed {
    logic        hit;
    logic [30:0] t_near;
    logic [30:0] t_far;
  } slab_result_t;

  typedef struct {
    logic signed [31:0] org[3];
    logic signed [15:0] dir[3];
  } ray_t;

  // One row of the directed table; has_ref marks rows with a typed-in result.
  typedef struct {
    ray_t         ray;
    bit           has_ref;
    slab_result_t ref_res;
  } ray_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // Fields from bit 0: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z.
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // Fields from bit 0: hit, t_near, t_far, zero bit.
  logic [63:0]  m_axis_tdata;
  logic         cfg_we = 1'b0;
  logic [rbs_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [31:0]  cfg_data = '0;

  // Testbench copy of the box registers: lower bounds then upper bounds.
  logic signed [31:0] box_lo[3];
  logic signed [31:0] box_hi[3];

  slab_result_t pending_hits[$];
  int  error_count = 0;
  bit  idle_free = 1'b0;   // set for a stretch with no idling at all

  ray_t     cur_ray;
  ray_row_t table_rows[$];

  always #6 clk = ~clk;

  ray_box_slab_intersection u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Intersects the three slabs in 64-bit arithmetic with truncating division.
  function automatic slab_result_t predict_hit(ray_t r);
    longint near_t, far_t, o, d, lo, hi, a, b, tn, tf;
    bit hit;
    slab_result_t res;
    near_t = -64'sd2147483648;
    far_t  = 64'sd2147483647;
    hit    = 1'b1;
    for (int i = 0; i < 3; i++) begin
      o  = r.org[i];
      d  = r.dir[i];
      lo = box_lo[i];
      hi = box_hi[i];
      if (d == 0) begin
        // A ray parallel to the slab only passes while it lies inside it.
        tn = -64'sd2147483648;
        tf = 64'sd2147483647;
        if (o < lo || o > hi) hit = 1'b0;
      end else begin
        a = clamp32(((lo - o) * 16384) / d);
        b = clamp32(((hi - o) * 16384) / d);
        tn = (d > 0) ? a : b;
        tf = (d > 0) ? b : a;
      end
      if (tn > near_t) near_t = tn;
      if (tf < far_t) far_t = tf;
    end
    if (near_t > far_t) hit = 1'b0;
    // With the origin inside the box the exit distance is reported as entry.
    if (hit && near_t < 0) begin
      near_t = far_t;
      if (far_t < 0) hit = 1'b0;
    end
    res.hit    = hit;
    res.t_near = hit ? near_t[30:0] : '0;
    res.t_far  = hit ? far_t[30:0] : '0;
    return res;
  endfunction

  task automatic write_box(input logic [rbs_pkg::CFG_ADDR_W-1:0] idx,
                           input logic signed [31:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx <= rbs_pkg::REG_BOX_MIN_Z) box_lo[idx] = v;
    else box_hi[idx - rbs_pkg::REG_BOX_MAX_X] = v;
  endtask

  task automatic load_box(input logic signed [31:0] lx, ly, lz, hx, hy, hz);
    write_box(rbs_pkg::REG_BOX_MIN_X, lx);
    write_box(rbs_pkg::REG_BOX_MIN_Y, ly);
    write_box(rbs_pkg::REG_BOX_MIN_Z, lz);
    write_box(rbs_pkg::REG_BOX_MAX_X, hx);
    write_box(rbs_pkg::REG_BOX_MAX_Y, hy);
    write_box(rbs_pkg::REG_BOX_MAX_Z, hz);
  endtask

  // Presents one ray at the falling edge and holds it until it is taken.
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_ray(input ray_t r, input bit has_ref, input slab_result_t ref_res);
    slab_result_t pred;
    while (!idle_free && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    pred = predict_hit(r);
    if (has_ref && pred != ref_res)
      $display("%0t: table entry disagrees with prediction exp=%h act=%h",
               $time, ref_res, pred);
    pending_hits.push_back(has_ref ? ref_res : pred);
    s_axis_tdata  <= {r.dir[2], r.dir[1], r.dir[0], r.org[2], r.org[1], r.org[0]};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Called at a falling edge; the last ray is withdrawn straight away.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_dir();
    case ($urandom_range(9))
      0: return 16'sd0;
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return 16'($urandom);                    // beyond the normalised range
      4: return 16'($urandom_range(1, 16));
      default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord(int span);
    if ($urandom_range(9) == 0) return $urandom;
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  // Random rays aimed mostly from around the box, so most reach deep decisions.
  task automatic random_rays(int count, int span);
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 3; i++) begin
        cur_ray.org[i] = rand_coord(span);
        cur_ray.dir[i] = rand_dir();
      end
      send_ray(cur_ray, 1'b0, '0);
    end
  endtask

  function automatic ray_row_t mk_row(logic signed [31:0] ox, oy, oz,
                                      logic signed [15:0] dx, dy, dz,
                                      bit has_ref, slab_result_t ref_res);
    ray_row_t row;
    row.ray.org[0] = ox; row.ray.org[1] = oy; row.ray.org[2] = oz;
    row.ray.dir[0] = dx; row.ray.dir[1] = dy; row.ray.dir[2] = dz;
    row.has_ref = has_ref;
    row.ref_res = ref_res;
    return row;
  endfunction

  // Result checker: compares each accepted result with the oldest expected result.
  always @(posedge clk) begin
    slab_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tdata[31:1], m_axis_tdata[62:32]};
      if (pending_hits.size() == 0) begin
        $display("%0t: result with no ray outstanding act=%h", $time, got);
        error_count++;
      end else begin
        want = pending_hits.pop_front();
        if (got.hit !== want.hit) begin
          $display("%0t: hit mismatch exp=%0d act=%0d", $time, want.hit, got.hit);
          error_count++;
        end
        if (got.t_near !== want.t_near) begin
          $display("%0t: t_near mismatch exp=%h act=%h", $time, want.t_near, got.t_near);
          error_count++;
        end
        if (got.t_far !== want.t_far) begin
          $display("%0t: t_far mismatch exp=%h act=%h", $time, want.t_far, got.t_far);
          error_count++;
        end
        if (m_axis_tdata[63] !== 1'b0) begin
          $display("%0t: fill bit exp=0 act=%b", $time, m_axis_tdata[63]);
          error_count++;
        end
      end
    end
  end

  // Receiver side: random back-pressure, none during the free stretch.
  always @(negedge clk) begin
    m_axis_tready <= idle_free || ($urandom_range(99) >= 20);
  end

  initial begin
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = rbs_pkg::BOX_MIN_RESET;
      box_hi[i] = rbs_pkg::BOX_MAX_RESET;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows against the reset box of +-50.0.
    // Straight down +x from -100: enters at 50.0 and leaves at 150.0.
    table_rows.push_back(mk_row(-32'sd6553600, 0, 0, 16'sd16384, 0, 0, 1'b1,
                                {1'b1, 31'd3276800, 31'd9830400}));
    // Same ray pointed away: both distances negative, a miss.
    table_rows.push_back(mk_row(-32'sd6553600, 0, 0, -16'sd16384, 0, 0, 1'b1, '0));
    // Origin inside and parallel to every axis: both distances saturate.
    table_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 1'b1,
                                {1'b1, 31'h7FFFFFFF, 31'h7FFFFFFF}));
    // Parallel to all axes but outside in x: a miss.
    table_rows.push_back(mk_row(32'sd6553600, 0, 0, 0, 0, 0, 1'b1, '0));
    // Origin at the centre along +x: exit distance doubles as entry.
    table_rows.push_back(mk_row(0, 0, 0, 16'sd16384, 0, 0, 1'b1,
                                {1'b1, 31'd3276800, 31'd3276800}));
    // Origin on the upper face going out: touching at distance zero.
    table_rows.push_back(mk_row(32'sd3276800, 0, 0, 16'sd16384, 0, 0, 1'b1,
                                {1'b1, 31'd0, 31'd0}));
    table_rows.push_back(mk_row(32'sd3276800, 0, 0, -16'sd16384, 0, 0, 1'b0, '0));
    // Extreme origins and directions, including beyond the normalised range.
    table_rows.push_back(mk_row(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                16'sd1, 16'sd1, 16'sd1, 1'b0, '0));
    table_rows.push_back(mk_row(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                -16'sd1, -16'sd1, -16'sd1, 1'b0, '0));
    table_rows.push_back(mk_row(32'sh7FFFFFFF, 32'sh80000000, 0,
                                16'sh8000, 16'sh7FFF, 16'sd16384, 1'b0, '0));
    table_rows.push_back(mk_row(-32'sd6553600, -32'sd6553600, -32'sd6553600,
                                16'sd9459, 16'sd9459, 16'sd9459, 1'b0, '0));
    // Grazing along an edge, and a diagonal that passes beside the box.
    table_rows.push_back(mk_row(-32'sd6553600, 32'sd3276800, 0, 16'sd16384, 0, 0, 1'b0, '0));
    table_rows.push_back(mk_row(-32'sd6553600, 32'sd6553600, 0,
                                16'sd11585, -16'sd4000, 0, 1'b0, '0));
    table_rows.push_back(mk_row(0, -32'sd6553600, 0, 0, 16'sd16384, 0, 1'b0, '0));
    table_rows.push_back(mk_row(0, 0, 32'sd6553600, 0, 0, -16'sd16384, 1'b0, '0));
    table_rows.push_back(mk_row(32'sd65536, 32'sd1, -32'sd1, 16'sd3, -16'sd7, 16'sd5, 1'b0, '0));
    foreach (table_rows[k])
      send_ray(table_rows[k].ray, table_rows[k].has_ref, table_rows[k].ref_res);
    drain();

    // Random phases over a range of boxes, the extremes and an inverted box.
    random_rays(150, 8000000);
    drain();
    load_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
             32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    random_rays(100, 32'h7FFFFFFF);
    drain();
    load_box(-32'sd655360, -32'sd131072, -32'sd20000000,
             32'sd1310720, 32'sd65536, 32'sd20000000);
    idle_free = 1'b1;
    random_rays(150, 6000000);
    drain();
    idle_free = 1'b0;
    // Inverted in y: every ray misses.
    load_box(-32'sd3276800, 32'sd3276800, -32'sd3276800,
             32'sd3276800, -32'sd3276800, 32'sd3276800);
    random_rays(50, 8000000);
    drain();
    load_box(rand_coord(4000000) - 32'sd4000000, rand_coord(4000000) - 32'sd4000000,
             rand_coord(4000000) - 32'sd4000000, rand_coord(4000000) + 32'sd4000000,
             rand_coord(4000000) + 32'sd4000000, rand_coord(4000000) + 32'sd4000000);
    random_rays(200, 10000000);
    drain();

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
